// ===== rtl/ppmfd_pkg.sv =====
package ppmfd_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned CH_W   = 4;

  localparam logic [DATA_W-1:0] MIN_WIDTH_RST  = 16'd600;
  localparam logic [DATA_W-1:0] MAX_WIDTH_RST  = 16'd2400;
  localparam logic [DATA_W-1:0] SYNC_GAP_RST   = 16'd3000;
  localparam logic [DATA_W-1:0] TIMEOUT_MS_RST = 16'd100;

  typedef enum logic [1:0] {
    CMD_COUNTER = 2'd0,
    CMD_CAPTURE = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MIN_WIDTH  = 2'd0,
    REG_MAX_WIDTH  = 2'd1,
    REG_SYNC_GAP   = 2'd2,
    REG_TIMEOUT_MS = 2'd3
  } reg_idx_e;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_LOSS   = 1'b1
  } kind_e;

  // Controller to datapath.
  typedef struct packed {
    logic            store_cap;
    logic            count_rst;
    logic            restart;
    logic            ms_inc;
    logic            ms_clr;
    logic            out_load;
    kind_e           out_kind;
    logic [CH_W-1:0] out_idx;
    logic            out_last;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic gap_det;
    logic in_window;
    logic count_full;
    logic count_nz;
    logic timed_out;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/ppmfd_in_if.sv =====
interface ppmfd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

// ===== rtl/ppmfd_out_if.sv =====
interface ppmfd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  channel;
  logic [15:0] width;
  logic        last;

  modport source (output valid, output kind, output channel, output width, output last,
                  input ready);
  modport sink (input valid, input kind, input channel, input width, input last,
                output ready);
endinterface

// ===== rtl/ppmfd_datapath.sv =====
module ppmfd_datapath #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ppmfd_pkg::DATA_W-1:0]   value_i,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [ppmfd_pkg::DATA_W-1:0]   cfg_data_i,
  input  ppmfd_pkg::ctrl_cmd_t           cmd_i,
  output ppmfd_pkg::dp_status_t          status_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           out_kind_o,
  output logic [ppmfd_pkg::CH_W-1:0]     out_channel_o,
  output logic [ppmfd_pkg::DATA_W-1:0]   out_width_o,
  output logic                           out_last_o
);

  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [ppmfd_pkg::DATA_W-1:0] min_width_q, max_width_q, sync_gap_q, timeout_ms_q;
  logic [ppmfd_pkg::DATA_W-1:0] store_q [NUM_CHANNELS];
  logic [CNT_W-1:0]             count_q, count_d;
  logic [ppmfd_pkg::DATA_W-1:0] ms_q, ms_d;

  logic                         out_valid_q;
  logic                         out_kind_q;
  logic [ppmfd_pkg::CH_W-1:0]   out_channel_q;
  logic [ppmfd_pkg::DATA_W-1:0] out_width_q;
  logic                         out_last_q;

  logic [ppmfd_pkg::DATA_W-1:0] rd_width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_width_q  <= ppmfd_pkg::MIN_WIDTH_RST;
      max_width_q  <= ppmfd_pkg::MAX_WIDTH_RST;
      sync_gap_q   <= ppmfd_pkg::SYNC_GAP_RST;
      timeout_ms_q <= ppmfd_pkg::TIMEOUT_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppmfd_pkg::REG_MIN_WIDTH:  min_width_q  <= cfg_data_i;
        ppmfd_pkg::REG_MAX_WIDTH:  max_width_q  <= cfg_data_i;
        ppmfd_pkg::REG_SYNC_GAP:   sync_gap_q   <= cfg_data_i;
        ppmfd_pkg::REG_TIMEOUT_MS: timeout_ms_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.restart || cmd_i.count_rst) begin
      count_d = '0;
    end else if (cmd_i.store_cap) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    ms_d = ms_q;
    if (cmd_i.restart || cmd_i.ms_clr) begin
      ms_d = '0;
    end else if (cmd_i.ms_inc) begin
      ms_d = ms_q + ppmfd_pkg::DATA_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ms_q    <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      count_q <= count_d;
      ms_q    <= ms_d;
      if (cmd_i.restart) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          store_q[i] <= '0;
        end
      end else if (cmd_i.store_cap) begin
        store_q[count_q[IDX_W-1:0]] <= value_i;
      end
    end
  end

  assign rd_width = store_q[cmd_i.out_idx[IDX_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q    <= cmd_i.out_kind;
      out_channel_q <= cmd_i.out_idx;
      out_last_q    <= cmd_i.out_last;
      out_width_q   <= (cmd_i.out_kind == ppmfd_pkg::KIND_LOSS) ? '0 : rd_width;
    end
  end

  assign status_o.gap_det    = value_i > sync_gap_q;
  assign status_o.in_window  = (value_i >= min_width_q) && (value_i <= max_width_q);
  assign status_o.count_full = count_q >= CNT_W'(NUM_CHANNELS);
  assign status_o.count_nz   = count_q != '0;
  assign status_o.timed_out  = ms_q >= timeout_ms_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_channel_o = out_channel_q;
  assign out_width_o   = out_width_q;
  assign out_last_o    = out_last_q;

endmodule

// ===== rtl/ppmfd_ctrl.sv =====
module ppmfd_ctrl #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_cmd_i,
  output logic                   in_ready_o,
  input  ppmfd_pkg::dp_status_t  status_i,
  output ppmfd_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_e;

  localparam logic [ppmfd_pkg::CH_W-1:0] LAST_IDX = ppmfd_pkg::CH_W'(NUM_CHANNELS - 1);

  state_e                     state_q, state_d;
  logic                       in_frame_q, in_frame_d;
  logic                       gap_seen_q, gap_seen_d;
  logic [ppmfd_pkg::CH_W-1:0] idx_q, idx_d;
  logic                       accept;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    in_frame_d = in_frame_q;
    gap_seen_d = gap_seen_q;
    idx_d      = idx_q;
    cmd_o      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            ppmfd_pkg::CMD_COUNTER: begin
              if (status_i.gap_det) begin
                if (in_frame_q && status_i.count_nz) begin
                  state_d      = ST_REPORT;
                  idx_d        = '0;
                  cmd_o.ms_clr = 1'b1;
                  in_frame_d   = 1'b0;
                end
                gap_seen_d = 1'b1;
              end
            end
            ppmfd_pkg::CMD_CAPTURE: begin
              if (!in_frame_q) begin
                // The first edge after a gap only opens the frame.
                if (gap_seen_q) begin
                  gap_seen_d      = 1'b0;
                  in_frame_d      = 1'b1;
                  cmd_o.count_rst = 1'b1;
                end
              end else if (!status_i.in_window) begin
                in_frame_d = 1'b0;
              end else if (!status_i.count_full) begin
                cmd_o.store_cap = 1'b1;
              end
            end
            ppmfd_pkg::CMD_TICK: begin
              if (status_i.timed_out) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_kind = ppmfd_pkg::KIND_LOSS;
                cmd_o.out_last = 1'b1;
                cmd_o.restart  = 1'b1;
                in_frame_d     = 1'b0;
                gap_seen_d     = 1'b0;
              end else begin
                cmd_o.ms_inc = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_REPORT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = ppmfd_pkg::KIND_REPORT;
          cmd_o.out_idx  = idx_q;
          cmd_o.out_last = idx_q == LAST_IDX;
          idx_d          = idx_q + ppmfd_pkg::CH_W'(1);
          if (idx_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_frame_q <= 1'b0;
      gap_seen_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      in_frame_q <= in_frame_d;
      gap_seen_q <= gap_seen_d;
      idx_q      <= idx_d;
    end
  end

endmodule

// ===== rtl/ppm_frame_decoder.sv =====
// Each input transfer is acted on when accepted; a loss result is shown the cycle after its tick.
// A frame report holds NUM_CHANNELS entries from the channel walk counter, one per cycle while
// the output is free, and no input is taken until its last entry is in the output register.
// Input is also held off while an unaccepted result sits in the one-deep output register.
// Asynchronous active-low reset restores the register defaults, clears all channel widths,
// the frame state and the millisecond counter.
module ppm_frame_decoder #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppmfd_in_if.sink    in_i,
  ppmfd_out_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  ppmfd_pkg::ctrl_cmd_t  cmd;
  ppmfd_pkg::dp_status_t status;

  ppmfd_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppmfd_datapath #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (in_i.value),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_kind_o    (out_o.kind),
    .out_channel_o (out_o.channel),
    .out_width_o   (out_o.width),
    .out_last_o    (out_o.last)
  );

endmodule
